// ----- design/adrp_pkg.sv -----
// Shared types and constants for the ASCII decimal record parser.
// No dependencies; imported by the parser top level and its port checker.
package adrp_pkg;

  // Field widths of one received byte and one record
  localparam int unsigned ByteW   = 8;
  localparam int unsigned SourceW = 4;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned CountW  = 16;
  localparam int unsigned IdxW    = 3;
  localparam int unsigned NumVals = 6;  // value_0 .. value_5 on the output
  localparam int unsigned ChanSlots = 4;

  // APB register map
  localparam int unsigned AddrW   = 4;
  localparam int unsigned DataW   = 32;
  localparam logic [1:0] RegSep   = 2'd0;
  localparam logic [1:0] RegEnd   = 2'd1;
  localparam logic [1:0] RegFirst = 2'd2;
  localparam logic [1:0] RegCalib = 2'd3;

  // Character constants and reset values
  localparam logic [ByteW-1:0] CharZero     = 8'd48;
  localparam logic [ByteW-1:0] SepReset     = 8'd44;
  localparam logic [ByteW-1:0] EndReset     = 8'd46;
  localparam logic [ByteW-1:0] FirstReset   = 8'd65;
  localparam logic [ByteW-1:0] CalibReset   = 8'd90;
  localparam logic [IdxW-1:0]  IdxMax       = 3'd7;

  typedef logic signed [ValueW-1:0] value_t;

  // One record as it sits in the output buffer
  typedef struct packed {
    logic [SourceW-1:0]       source;
    value_t [NumVals-1:0]     value;
    logic [CountW-1:0]        count;
  } record_t;

endpackage

// ----- design/ascii_decimal_record_parser_unit.sv -----
// ASCII decimal record parser: header/field/end byte parser with APB setup registers.
// Depends on adrp_pkg; checked by adrp_port_checker (bound in its own file).
//
//  channel | signals                                   | beat
//  --------+-------------------------------------------+---------------------------
//  input   | in_valid_i / in_ready_o, rx_byte_i        | one received byte
//  output  | out_valid_o / out_ready_i, source_o,      | one record
//          | value_0_o..value_5_o, packet_count_o      |
//  config  | psel, penable, pwrite, paddr, pwdata,     | one register write or read
//          | prdata, pready                            |
//
// One byte per cycle while the output buffer has room. A byte is parsed straight out of the
// input register once an output entry is free; its record (if any) is buffered then.
// Records go into a two-entry output buffer; input stalls only while both entries are full
// (the parse step needs one free entry since any byte may be an end byte).
// Reset clears parser state, stored fields, counter and buffer at once; no clearing pass.
module ascii_decimal_record_parser_unit
  import adrp_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 8,
  parameter int unsigned CALIB_FIELDS = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // byte input
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ByteW-1:0]     rx_byte_i,
  // record output
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [SourceW-1:0]   source_o,
  output logic signed [ValueW-1:0] value_0_o,
  output logic signed [ValueW-1:0] value_1_o,
  output logic signed [ValueW-1:0] value_2_o,
  output logic signed [ValueW-1:0] value_3_o,
  output logic signed [ValueW-1:0] value_4_o,
  output logic signed [ValueW-1:0] value_5_o,
  output logic [CountW-1:0]    packet_count_o,
  // APB setup port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrW-1:0]     paddr,
  input  logic [DataW-1:0]     pwdata,
  output logic [DataW-1:0]     prdata,
  output logic                 pready
);

  // Parser states
  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StChan  = 2'd1;
  localparam logic [1:0] StCalib = 2'd2;

  localparam logic [SourceW-1:0] CalibSource = SourceW'(NUM_CHANNELS);

  // ---------------------------------------------------------------------------
  // Setup registers
  logic [ByteW-1:0] sep_q, end_q, first_q, calib_q;
  logic             cfg_wr;
  logic [1:0]       cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[AddrW-1:2];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q   <= SepReset;
      end_q   <= EndReset;
      first_q <= FirstReset;
      calib_q <= CalibReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegSep:   sep_q   <= pwdata[ByteW-1:0];
        RegEnd:   end_q   <= pwdata[ByteW-1:0];
        RegFirst: first_q <= pwdata[ByteW-1:0];
        RegCalib: calib_q <= pwdata[ByteW-1:0];
        default:  ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      RegSep:   prdata[ByteW-1:0] = sep_q;
      RegEnd:   prdata[ByteW-1:0] = end_q;
      RegFirst: prdata[ByteW-1:0] = first_q;
      RegCalib: prdata[ByteW-1:0] = calib_q;
      default:  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register
  logic             s1_valid_q;
  logic [ByteW-1:0] s1_byte_q;
  logic             buf_full;
  logic             adv;

  assign adv        = s1_valid_q & ~buf_full;
  assign in_ready_o = ~s1_valid_q | ~buf_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q <= rx_byte_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Parser state
  logic [1:0]         st_q, st_d;
  logic [SourceW-1:0] chan_q, chan_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [ValueW-1:0]  acc_q, acc_d;
  logic [ValueW-1:0]  chv_q [ChanSlots];
  logic [ValueW-1:0]  chv_d [ChanSlots];
  logic [ValueW-1:0]  cal_q [CALIB_FIELDS];
  logic [ValueW-1:0]  cal_d [CALIB_FIELDS];
  logic [CountW-1:0]  cnt_q, cnt_d;
  logic               emit;
  record_t            rec;

  // Header decode while idle: higher channel wins; the state logic gives calibration priority
  logic               hdr_hit;
  logic [SourceW-1:0] hdr_ch;
  always_comb begin
    hdr_hit = 1'b0;
    hdr_ch  = '0;
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      if (s1_byte_q == ByteW'(first_q + ByteW'(k))) begin
        hdr_hit = 1'b1;
        hdr_ch  = SourceW'(k);
      end
    end
  end

  // One accumulate step: acc*10 + (byte - '0'), wrapping
  logic [ValueW-1:0] acc_step;
  logic              own_hdr;
  assign acc_step = (acc_q << 3) + (acc_q << 1)
                  + ({{(ValueW-ByteW){1'b0}}, s1_byte_q} - ValueW'(CharZero));
  assign own_hdr  = (s1_byte_q == ByteW'(first_q + ByteW'(chan_q)));

  // Next-state logic for one byte
  always_comb begin
    logic do_store;
    do_store = 1'b0;
    st_d     = st_q;
    chan_d   = chan_q;
    idx_d    = idx_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    emit     = 1'b0;
    chv_d    = chv_q;
    cal_d    = cal_q;

    unique case (st_q)
      StIdle: begin
        if (s1_byte_q == calib_q) begin
          st_d  = StCalib;
          idx_d = '0;
          acc_d = '0;
        end else if (hdr_hit) begin
          st_d   = StChan;
          chan_d = hdr_ch;
          idx_d  = '0;
          acc_d  = '0;
        end
      end
      StChan, StCalib: begin
        if (s1_byte_q == end_q) begin
          do_store = 1'b1;
          emit     = 1'b1;
          st_d     = StIdle;
          idx_d    = '0;
          acc_d    = '0;
          if (st_q == StChan) begin
            cnt_d = cnt_q + CountW'(1);
          end
        end else if (st_q == StChan && own_hdr) begin
          idx_d = '0;
          acc_d = '0;
        end else if (s1_byte_q == sep_q) begin
          do_store = 1'b1;
          acc_d    = '0;
          if (idx_q < IdxMax) begin
            idx_d = idx_q + IdxW'(1);
          end
        end else begin
          acc_d = acc_step;
        end
      end
      default: st_d = StIdle;
    endcase

    // store the running field into its slot; indexes past the slots are dropped
    if (do_store) begin
      if (st_q == StCalib) begin
        for (int i = 0; i < CALIB_FIELDS; i++) begin
          if (idx_q == IdxW'(i)) cal_d[i] = acc_q;
        end
      end else begin
        for (int i = 0; i < ChanSlots; i++) begin
          if (idx_q == IdxW'(i)) chv_d[i] = acc_q;
        end
      end
    end

    // record built from the slots after this store
    rec.count = cnt_d;
    if (st_q == StCalib) begin
      rec.source = CalibSource;
      for (int i = 0; i < NumVals; i++) begin
        rec.value[i] = '0;
        if (i < CALIB_FIELDS) rec.value[i] = cal_d[i];
      end
    end else begin
      rec.source = chan_q;
      for (int i = 0; i < NumVals; i++) begin
        rec.value[i] = '0;
        if (i < ChanSlots) rec.value[i] = chv_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StIdle;
      chan_q <= '0;
      idx_q  <= '0;
      acc_q  <= '0;
      cnt_q  <= '0;
      for (int i = 0; i < ChanSlots; i++) chv_q[i] <= '0;
      for (int i = 0; i < CALIB_FIELDS; i++) cal_q[i] <= '0;
    end else if (adv) begin
      st_q   <= st_d;
      chan_q <= chan_d;
      idx_q  <= idx_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      chv_q  <= chv_d;
      cal_q  <= cal_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Two-entry output buffer
  record_t    obuf_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] ocnt_q;
  logic       buf_wr, buf_rd;

  assign buf_full    = (ocnt_q == 2'd2);
  assign out_valid_o = (ocnt_q != 2'd0);
  assign buf_wr      = adv & emit;
  assign buf_rd      = out_valid_o & out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      ocnt_q   <= '0;
    end else begin
      if (buf_wr) wr_ptr_q <= ~wr_ptr_q;
      if (buf_rd) rd_ptr_q <= ~rd_ptr_q;
      ocnt_q <= ocnt_q + {1'b0, buf_wr} - {1'b0, buf_rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (buf_wr) begin
      obuf_q[wr_ptr_q] <= rec;
    end
  end

  assign source_o       = obuf_q[rd_ptr_q].source;
  assign value_0_o      = obuf_q[rd_ptr_q].value[0];
  assign value_1_o      = obuf_q[rd_ptr_q].value[1];
  assign value_2_o      = obuf_q[rd_ptr_q].value[2];
  assign value_3_o      = obuf_q[rd_ptr_q].value[3];
  assign value_4_o      = obuf_q[rd_ptr_q].value[4];
  assign value_5_o      = obuf_q[rd_ptr_q].value[5];
  assign packet_count_o = obuf_q[rd_ptr_q].count;

endmodule

// ----- design/adrp_port_checker.sv -----
// Port-level checks for the ASCII decimal record parser.
// Depends on adrp_pkg; bound to ascii_decimal_record_parser_unit at the end of this file.
module adrp_port_checker
  import adrp_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 8
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic [SourceW-1:0]       source_o,
  input logic signed [ValueW-1:0] value_4_o,
  input logic signed [ValueW-1:0] value_5_o,
  input logic [CountW-1:0]        packet_count_o
);

  localparam logic [SourceW-1:0] CalibSource = SourceW'(NUM_CHANNELS);
  localparam bit Distinct = (NUM_CHANNELS < 16);

  logic chan_rec;
  assign chan_rec = Distinct && (source_o != CalibSource);

  // last packet count seen on a channel record
  logic              seen_q;
  logic [CountW-1:0] last_cnt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 1'b0;
      last_cnt_q <= '0;
    end else if (out_valid_o && out_ready_i && chan_rec) begin
      seen_q     <= 1'b1;
      last_cnt_q <= packet_count_o;
    end
  end

  // a waiting record holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(source_o)
      && $stable(packet_count_o))
    else $error("record changed while stalled");

  // source is a channel number or the calibration code
  a_source_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (source_o < SourceW'(NUM_CHANNELS)) || (source_o == CalibSource)
      || (NUM_CHANNELS >= 16))
    else $error("record source out of range");

  // channel records carry zero in the calibration-only fields
  a_chan_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && chan_rec |-> (value_4_o == '0) && (value_5_o == '0))
    else $error("channel record with nonzero calibration field");

  // consecutive channel records count up by one
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && chan_rec && seen_q |-> packet_count_o == last_cnt_q + CountW'(1))
    else $error("packet count skipped or repeated");

  // no record appears out of a reset-idle block without a prior input beat
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2)
      || $past(out_valid_o, 2) || $past(!in_ready_o, 2) || $past(!in_ready_o, 1))
    else $error("record without a preceding byte");

endmodule

bind ascii_decimal_record_parser_unit adrp_port_checker #(
  .NUM_CHANNELS (NUM_CHANNELS)
) u_adrp_port_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .source_o       (source_o),
  .value_4_o      (value_4_o),
  .value_5_o      (value_5_o),
  .packet_count_o (packet_count_o)
);

// ----- tb/sv/tb_ascii_decimal_record_parser_unit.sv -----
// Self-checking testbench for the ASCII decimal record parser top level.
// Depends on adrp_pkg and ascii_decimal_record_parser_unit; the byte decoder is modeled
// here and every record beat is checked against it, across several register settings.
module tb_ascii_decimal_record_parser_unit;
  import adrp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumChannels = 8;
  localparam int CalibFields = 6;
  localparam int SettleCycles = 10;
  localparam int CycleLimit = 400000;
  localparam int PhaseBytes = 100;

  typedef enum logic [1:0] {
    WaitHeader,
    InChannel,
    InCalib
  } parse_state_e;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [ByteW-1:0]         rx_byte_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [SourceW-1:0]       source_o;
  logic signed [ValueW-1:0] value_0_o, value_1_o, value_2_o;
  logic signed [ValueW-1:0] value_3_o, value_4_o, value_5_o;
  logic [CountW-1:0]        packet_count_o;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [AddrW-1:0]         paddr = '0;
  logic [DataW-1:0]         pwdata = '0;
  logic [DataW-1:0]         prdata;
  logic                     pready;

  // Decoder model state and its copy of the setup registers
  logic [ByteW-1:0]  cfg_sep, cfg_end, cfg_first, cfg_calib;
  parse_state_e      parse_state;
  int                cur_chan;
  logic [IdxW-1:0]   field_idx;
  logic [ValueW-1:0] acc;
  logic [ValueW-1:0] chan_slot [ChanSlots];
  logic [ValueW-1:0] calib_slot [CalibFields];
  logic [CountW-1:0] done_packets;

  record_t expected_records[$];
  int      error_count = 0;
  int      cycle_count = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;

  ascii_decimal_record_parser_unit #(
    .NUM_CHANNELS(NumChannels),
    .CALIB_FIELDS(CalibFields)
  ) DUT (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .rx_byte_i,
    .out_valid_o, .out_ready_i, .source_o,
    .value_0_o, .value_1_o, .value_2_o, .value_3_o, .value_4_o, .value_5_o,
    .packet_count_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb_ascii_decimal_record_parser_unit failed");
      $finish;
    end
  end

  // Output back-pressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Record checker: every output beat against the oldest expected record
  always @(posedge clk_i) begin
    record_t got;
    record_t want;
    if (out_valid_o && out_ready_i) begin
      got.source   = source_o;
      got.value[0] = value_0_o;
      got.value[1] = value_1_o;
      got.value[2] = value_2_o;
      got.value[3] = value_3_o;
      got.value[4] = value_4_o;
      got.value[5] = value_5_o;
      got.count    = packet_count_o;
      if (expected_records.size() == 0) begin
        $display("%0t: unexpected record, source %0d", $time, got.source);
        error_count++;
      end else begin
        want = expected_records.pop_front();
        if (got.source !== want.source) begin
          $display("%0t: source expected %0d actual %0d", $time, want.source, got.source);
          error_count++;
        end
        for (int k = 0; k < NumVals; k++) begin
          if (got.value[k] !== want.value[k]) begin
            $display("%0t: value_%0d expected %0d actual %0d", $time, k,
                     want.value[k], got.value[k]);
            error_count++;
          end
        end
        if (got.count !== want.count) begin
          $display("%0t: packet_count expected %0d actual %0d", $time, want.count,
                   got.count);
          error_count++;
        end
      end
    end
  end

  // Store the running field into the slot of the current packet type
  function automatic void store_field();
    if (parse_state == InCalib) begin
      if (field_idx < CalibFields) calib_slot[field_idx] = acc;
    end else if (field_idx < ChanSlots) begin
      chan_slot[field_idx] = acc;
    end
    acc = '0;
  endfunction

  // Byte decoder model; queues the record an end byte produces
  function automatic void decode_byte(input logic [ByteW-1:0] b);
    parse_state_e nxt;
    int           nxt_chan;
    record_t      rec;
    logic [ByteW-1:0] own_hdr;
    own_hdr = cfg_first + ByteW'(cur_chan);
    if (parse_state == WaitHeader) begin
      nxt = WaitHeader;
      nxt_chan = 0;
      // higher channel wins, calibration header wins over all
      for (int k = 0; k < NumChannels; k++) begin
        if (b == ByteW'(cfg_first + ByteW'(k))) begin
          nxt = InChannel;
          nxt_chan = k;
        end
      end
      if (b == cfg_calib) nxt = InCalib;
      if (nxt != WaitHeader) begin
        parse_state = nxt;
        cur_chan = nxt_chan;
        field_idx = '0;
        acc = '0;
      end
    end else if (b == cfg_end) begin
      store_field();
      rec = '0;
      if (parse_state == InCalib) begin
        rec.source = SourceW'(NumChannels);
        for (int k = 0; k < NumVals && k < CalibFields; k++) rec.value[k] = calib_slot[k];
      end else begin
        done_packets = done_packets + 1'b1;
        rec.source = SourceW'(cur_chan);
        for (int k = 0; k < ChanSlots; k++) rec.value[k] = chan_slot[k];
      end
      rec.count = done_packets;
      expected_records.push_back(rec);
      parse_state = WaitHeader;
      field_idx = '0;
    end else if (parse_state == InChannel && b == own_hdr) begin
      // own header again: restart, stored slots kept
      acc = '0;
      field_idx = '0;
    end else if (b == cfg_sep) begin
      store_field();
      if (field_idx < IdxMax) field_idx = field_idx + 1'b1;
    end else begin
      acc = acc * 32'd10 + (ValueW'(b) - ValueW'(CharZero));
    end
  endfunction

  // One byte beat, with a random idle gap ahead of it
  task automatic send_byte(input logic [ByteW-1:0] b);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    decode_byte(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Drop valid and let every queued record drain before touching registers
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // APB write of one register, then a read back of it
  task automatic write_reg(input logic [1:0] idx, input logic [ByteW-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'($urandom), val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[ByteW-1:0] !== val) begin
      $display("%0t: register %0d read expected %0d actual %0d", $time, idx, val,
               prdata[ByteW-1:0]);
      error_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    case (idx)
      RegSep:   cfg_sep = val;
      RegEnd:   cfg_end = val;
      RegFirst: cfg_first = val;
      RegCalib: cfg_calib = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [ByteW-1:0] sep, input logic [ByteW-1:0] fin,
                            input logic [ByteW-1:0] first, input logic [ByteW-1:0] cal);
    write_reg(RegSep, sep);
    write_reg(RegEnd, fin);
    write_reg(RegFirst, first);
    write_reg(RegCalib, cal);
  endtask

  // One packet with random content; a few are noise, cut short or restarted.
  // Returns the number of packet bytes sent (noise is not counted).
  task automatic send_random_packet(output int nbytes);
    int kind, nfields, ndig, chan;
    logic [ByteW-1:0] hdr;
    nbytes = 0;
    kind = $urandom_range(99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 6)) send_byte(ByteW'($urandom));
    end else begin
      chan = $urandom_range(NumChannels - 1);
      hdr = ($urandom_range(3) == 0) ? cfg_calib : ByteW'(cfg_first + ByteW'(chan));
      send_byte(hdr);
      nbytes++;
      nfields = ($urandom_range(9) == 0) ? $urandom_range(7, 10) : $urandom_range(1, 6);
      for (int f = 0; f < nfields; f++) begin
        if (f > 0) begin
          send_byte(cfg_sep);
          nbytes++;
        end
        if (kind < 14 && f == nfields / 2) begin
          send_byte(hdr);
          nbytes++;
        end
        ndig = ($urandom_range(7) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 5);
        repeat (ndig) begin
          if ($urandom_range(19) == 0) send_byte(ByteW'($urandom));
          else send_byte(CharZero + ByteW'($urandom_range(9)));
          nbytes++;
        end
      end
      // a few packets are left open; the next header then lands mid-packet
      if (kind >= 20 || kind < 14) begin
        send_byte(cfg_end);
        nbytes++;
      end
    end
  endtask

  task automatic run_random_phase(input int send_pct, input int stall_pct);
    int sent, nb;
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < PhaseBytes) begin
      send_random_packet(nb);
      sent += nb;
    end
    settle();
  endtask

  task automatic reset_model();
    cfg_sep = SepReset;
    cfg_end = EndReset;
    cfg_first = FirstReset;
    cfg_calib = CalibReset;
    parse_state = WaitHeader;
    cur_chan = 0;
    field_idx = '0;
    acc = '0;
    foreach (chan_slot[k]) chan_slot[k] = '0;
    foreach (calib_slot[k]) calib_slot[k] = '0;
    done_packets = '0;
  endtask

  // Reset values: idle junk, calibration packet, channel packet with restart and overflow
  task automatic test_directed_packets();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("ZA7,8.");
    send_byte("H");
    send_byte(8'hFF);
    send_text(",9H5,,,,,,,,1.");
    settle();
  endtask

  // All-low and all-high register codes: calibration, first channel header, separator and end collide
  task automatic test_extreme_settings();
    set_config(8'h00, 8'h00, 8'h00, 8'h00);
    run_random_phase(0, 0);
    set_config(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    run_random_phase(82, 0);
  endtask

  // Calibration header on a channel code, and channel codes wrapping past 255
  task automatic test_header_collisions();
    set_config(SepReset, EndReset, CalibReset - 8'd3, CalibReset);
    run_random_phase(0, 82);
    set_config(8'h0A, 8'h0D, 8'd252, 8'd1);
    run_random_phase(36, 36);
  endtask

  task automatic test_random_settings();
    set_config(ByteW'($urandom), ByteW'($urandom), ByteW'($urandom), ByteW'($urandom));
    run_random_phase(0, 0);
    set_config(SepReset, EndReset, FirstReset, CalibReset);
    run_random_phase(82, 0);
    set_config(ByteW'($urandom), ByteW'($urandom), ByteW'($urandom), ByteW'($urandom));
    run_random_phase(0, 82);
    set_config(SepReset, EndReset, FirstReset, CalibReset);
    run_random_phase(36, 36);
  endtask

  initial begin
    reset_model();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_packets();
    test_extreme_settings();
    test_header_collisions();
    test_random_settings();
    if (error_count == 0) begin
      $display("tb_ascii_decimal_record_parser_unit passed");
    end else begin
      $display("tb_ascii_decimal_record_parser_unit failed");
    end
    $finish;
  end

endmodule

// ----- ascii_decimal_record_parser_unit.f -----
design/adrp_pkg.sv
design/ascii_decimal_record_parser_unit.sv
design/adrp_port_checker.sv
tb/sv/tb_ascii_decimal_record_parser_unit.sv
